// ===== hdl/fss_pkg.sv =====
// Shared types and constants for the fuzzy subsequence scorer.
// No dependencies; imported by fss_regs, fuzzy_subsequence_scorer and the testbench.
package fss_pkg;

  localparam int ADDR_W      = 6;
  localparam int DATA_W      = 64;
  localparam int QUERY_BYTES = 32;
  localparam int QWORDS      = 4;

  typedef struct packed {
    logic [QWORDS-1:0][DATA_W-1:0] query_word;
    logic [5:0]                    query_length;
    logic                          host_enable;
    logic                          tags_enable;
  } cfg_t;

endpackage

// ===== hdl/fss_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on fss_pkg for cfg_t and port widths.
module fss_regs
  import fss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  typedef enum logic [2:0] {
    REG_QUERY_W0  = 3'd0,
    REG_QUERY_W1  = 3'd1,
    REG_QUERY_W2  = 3'd2,
    REG_QUERY_W3  = 3'd3,
    REG_QUERY_LEN = 3'd4,
    REG_HOST_EN   = 3'd5,
    REG_TAGS_EN   = 3'd6
  } reg_index_t;

  logic [2:0] index;
  logic       write_en;

  assign index    = paddr[ADDR_W-1:3];
  assign pready   = 1'b1;
  assign write_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.query_word   <= '0;
      cfg.query_length <= '0;
      cfg.host_enable  <= 1'b1;
      cfg.tags_enable  <= 1'b1;
    end else if (write_en) begin
      unique case (index)
        REG_QUERY_W0:  cfg.query_word[0] <= pwdata;
        REG_QUERY_W1:  cfg.query_word[1] <= pwdata;
        REG_QUERY_W2:  cfg.query_word[2] <= pwdata;
        REG_QUERY_W3:  cfg.query_word[3] <= pwdata;
        REG_QUERY_LEN: cfg.query_length <= pwdata[5:0];
        REG_HOST_EN:   cfg.host_enable  <= pwdata[0];
        REG_TAGS_EN:   cfg.tags_enable  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_QUERY_W0:  prdata = cfg.query_word[0];
      REG_QUERY_W1:  prdata = cfg.query_word[1];
      REG_QUERY_W2:  prdata = cfg.query_word[2];
      REG_QUERY_W3:  prdata = cfg.query_word[3];
      REG_QUERY_LEN: prdata = DATA_W'(cfg.query_length);
      REG_HOST_EN:   prdata = DATA_W'(cfg.host_enable);
      REG_TAGS_EN:   prdata = DATA_W'(cfg.tags_enable);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== hdl/fuzzy_subsequence_scorer.sv =====
// Top level: input stage, scoring state and result register.
// Depends on fss_pkg and fss_regs.
//
//  channel   handshake                 payload
//  item      item_valid / item_ready   string_kind char_present target_char
//                                      string_end record_end
//  result    result_valid/result_ready best_score matched
//  config    psel penable pwrite       paddr pwdata prdata (pready tied high)
//
// One item per cycle unless a record end waits on a stalled result. Items are
// scored from the input stage; a record's result loads as its end is scored.
// The per-string running state closes a registered feedback loop on each item.
// Reset clears the scoring state and both valid flags; there is no clearing pass.
// A stalled result stalls the input only while a record-end item waits in the stage.
module fuzzy_subsequence_scorer
  import fss_pkg::*;
#(
  parameter int QUERY_CHARS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [1:0]        string_kind,
  input  logic              char_present,
  input  logic [7:0]        target_char,
  input  logic              string_end,
  input  logic              record_end,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [10:0]       best_score,
  output logic              matched
);

  localparam logic [1:0]  KIND_NAME  = 2'd0;
  localparam logic [1:0]  KIND_HOST  = 2'd1;
  localparam logic [1:0]  KIND_TAGS  = 2'd2;
  localparam logic [7:0]  CHAR_STAR  = 8'h2A;
  localparam logic [7:0]  CHAR_SPACE = 8'h20;
  localparam logic [7:0]  CHAR_DASH  = 8'h2D;
  localparam logic [7:0]  CHAR_UNDER = 8'h5F;
  localparam logic [7:0]  CASE_GAP   = 8'd32;
  localparam logic [7:0]  WORD_BONUS = 8'd5;
  localparam logic [10:0] SCORE_MAX  = 11'h7FF;
  localparam logic [5:0]  QLIM       = 6'(QUERY_CHARS);

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + CASE_GAP : c;
  endfunction

  cfg_t cfg;

  fss_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [QUERY_BYTES-1:0][7:0] qbytes;
  logic [5:0] qlen;
  logic       star;

  assign qbytes = cfg.query_word;
  assign qlen   = (cfg.query_length > QLIM) ? QLIM : cfg.query_length;

  always_comb begin
    star = 1'b0;
    for (int i = 0; i < QUERY_BYTES; i++) begin
      if (6'(i) < qlen && qbytes[i] == CHAR_STAR) begin
        star = 1'b1;
      end
    end
  end

  logic       stage_valid;
  logic [1:0] stage_kind;
  logic       stage_present;
  logic [7:0] stage_char;
  logic       stage_string_end;
  logic       stage_record_end;
  logic       advance;

  assign advance    = stage_valid && (!stage_record_end || !result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage_kind       <= string_kind;
      stage_present    <= char_present;
      stage_char       <= target_char;
      stage_string_end <= string_end;
      stage_record_end <= record_end;
    end
  end

  logic [5:0]  query_position, query_position_next;
  logic [5:0]  run_length, run_length_next;
  logic [10:0] string_score, string_score_next;
  logic [7:0]  previous_char, previous_char_next;
  logic        at_string_start, at_string_start_next;
  logic        string_seen, string_seen_next;
  logic [10:0] record_best, record_best_next;
  logic [10:0] result_next;

  logic        kind_en;
  logic        word_start;
  logic [7:0]  add;
  logic [11:0] sum;
  logic [10:0] str_result;

  always_comb begin
    query_position_next  = query_position;
    run_length_next      = run_length;
    string_score_next    = string_score;
    previous_char_next   = previous_char;
    at_string_start_next = at_string_start;
    string_seen_next     = string_seen;
    record_best_next     = record_best;
    result_next          = '0;
    word_start = at_string_start || previous_char == CHAR_SPACE ||
                 previous_char == CHAR_DASH || previous_char == CHAR_UNDER;
    add = {({1'b0, run_length} + 7'd1), 1'b0} + (word_start ? WORD_BONUS : 8'd0);
    sum = 12'(string_score) + 12'(add);
    kind_en = stage_kind == KIND_NAME || (stage_kind == KIND_HOST && cfg.host_enable) ||
              (stage_kind == KIND_TAGS && cfg.tags_enable);

    if (kind_en) begin
      string_seen_next = 1'b1;
      if (stage_present) begin
        if (query_position < qlen) begin
          if (fold(qbytes[query_position[4:0]]) == fold(stage_char)) begin
            query_position_next = query_position + 6'd1;
            run_length_next     = run_length + 6'd1;
            string_score_next   = (sum > 12'(SCORE_MAX)) ? SCORE_MAX : sum[10:0];
          end else begin
            run_length_next = '0;
          end
        end
        previous_char_next   = stage_char;
        at_string_start_next = 1'b0;
      end
    end

    if (star) begin
      str_result = 11'd1;
    end else if (query_position_next == qlen) begin
      str_result = string_score_next;
    end else begin
      str_result = '0;
    end

    if (stage_string_end || stage_record_end) begin
      if (string_seen_next && str_result > record_best) begin
        record_best_next = str_result;
      end
      query_position_next  = '0;
      run_length_next      = '0;
      string_score_next    = '0;
      previous_char_next   = '0;
      at_string_start_next = 1'b1;
      string_seen_next     = 1'b0;
    end

    if (stage_record_end) begin
      result_next      = (qlen == '0) ? 11'd1 : record_best_next;
      record_best_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_position  <= '0;
      run_length      <= '0;
      string_score    <= '0;
      previous_char   <= '0;
      at_string_start <= 1'b1;
      string_seen     <= 1'b0;
      record_best     <= '0;
    end else if (advance) begin
      query_position  <= query_position_next;
      run_length      <= run_length_next;
      string_score    <= string_score_next;
      previous_char   <= previous_char_next;
      at_string_start <= at_string_start_next;
      string_seen     <= string_seen_next;
      record_best     <= record_best_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && stage_record_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_record_end) begin
      best_score <= result_next;
      matched    <= result_next != '0;
    end
  end

`ifndef SYNTH
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> stage_valid && stage_record_end && result_valid && !result_ready)
    else $error("item stage stalled without a blocked result");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    advance && stage_record_end |=> result_valid)
    else $error("record end did not load the result register");

  a_matched: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> matched == (best_score != '0))
    else $error("matched disagrees with best_score");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid && !stage_valid && record_best == '0)
    else $error("state not cleared by reset");
`endif

endmodule

// ===== test/fuzzy_subsequence_scorer_test.sv =====
`timescale 1ns / 1ps
// Testbench for fuzzy_subsequence_scorer: directed and random records are scored by an
// in-bench predictor, and each result transfer is checked against it, under varied idling.
// Depends on fss_pkg and the fuzzy_subsequence_scorer RTL.
module fuzzy_subsequence_scorer_test
  import fss_pkg::*;
();

  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_HOST  = 2'd1;
  localparam logic [1:0] KIND_TAGS  = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [ADDR_W-1:0] ADDR_QUERY_WORD   = 6'd0;
  localparam logic [ADDR_W-1:0] ADDR_QUERY_LENGTH = 6'd32;
  localparam logic [ADDR_W-1:0] ADDR_HOST_ENABLE  = 6'd40;
  localparam logic [ADDR_W-1:0] ADDR_TAGS_ENABLE  = 6'd48;

  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_DASH       = 8'h2D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DIGIT_0    = 8'h30;
  localparam logic [7:0] UPPER_A       = 8'h41;
  localparam logic [7:0] UPPER_Z       = 8'h5A;
  localparam logic [7:0] LOWER_A       = 8'h61;
  localparam logic [7:0] LOWER_Z       = 8'h7A;
  localparam logic [7:0] CASE_STEP     = 8'd32;

  localparam int unsigned WORD_BONUS    = 5;
  localparam int unsigned SCORE_CAP     = 2047;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          STALL_LIMIT   = 4000;

  typedef struct packed {
    logic [1:0] kind;
    logic       present;
    logic [7:0] ch;
    logic       s_end;
    logic       r_end;
  } char_item_t;

  typedef struct packed {
    logic [10:0] score;
    logic        hit;
  } score_t;

  typedef logic [7:0] byte_q_t[$];

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              item_valid = 1'b0;
  logic              item_ready;
  logic [1:0]        string_kind = '0;
  logic              char_present = 1'b0;
  logic [7:0]        target_char = '0;
  logic              string_end = 1'b0;
  logic              record_end = 1'b0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic [10:0]       best_score;
  logic              matched;

  fuzzy_subsequence_scorer uut (.*);

  // predictor copy of configuration and scoring state
  logic [DATA_W-1:0] q_word [QWORDS] = '{default: '0};
  logic [5:0]        q_len = '0;
  logic              host_on = 1'b1;
  logic              tags_on = 1'b1;
  int unsigned       q_pos = 0;
  int unsigned       run_len = 0;
  int unsigned       str_score = 0;
  logic [7:0]        prev_ch = '0;
  bit                at_start = 1'b1;
  bit                str_seen = 1'b0;
  int unsigned       rec_best = 0;

  score_t      expected_scores[$];
  score_t      next_score;
  int          error_count = 0;
  int          stall_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned items_sent = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [7:0] swap_case(input logic [7:0] c);
    if (c >= LOWER_A && c <= LOWER_Z) return c - CASE_STEP;
    if (c >= UPPER_A && c <= UPPER_Z) return c + CASE_STEP;
    return c;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= UPPER_A && c <= UPPER_Z) ? c + CASE_STEP : c;
  endfunction

  function automatic logic [7:0] query_char(input int unsigned i);
    return q_word[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic int unsigned active_length();
    return (q_len > QUERY_BYTES) ? QUERY_BYTES : q_len;
  endfunction

  task automatic clear_string();
    q_pos = 0;
    run_len = 0;
    str_score = 0;
    prev_ch = '0;
    at_start = 1'b1;
    str_seen = 1'b0;
  endtask

  task automatic score_item(input char_item_t it);
    int unsigned qlen;
    int unsigned closing;
    bit          enabled;
    bit          word_start;
    bit          has_star;
    score_t      want;
    qlen = active_length();
    enabled = it.kind == KIND_NAME || (it.kind == KIND_HOST && host_on) ||
              (it.kind == KIND_TAGS && tags_on);
    if (enabled) begin
      str_seen = 1'b1;
      if (it.present) begin
        if (q_pos < qlen) begin
          if (fold_case(query_char(q_pos)) == fold_case(it.ch)) begin
            word_start = at_start || prev_ch == CH_SPACE || prev_ch == CH_DASH ||
                         prev_ch == CH_UNDERSCORE;
            str_score += 2 * (run_len + 1) + (word_start ? WORD_BONUS : 0);
            if (str_score > SCORE_CAP) str_score = SCORE_CAP;
            q_pos++;
            run_len = (run_len + 1) % 64;
          end else begin
            run_len = 0;
          end
        end
        prev_ch = it.ch;
        at_start = 1'b0;
      end
    end
    if (it.s_end || it.r_end) begin
      if (str_seen) begin
        has_star = 1'b0;
        for (int i = 0; i < qlen; i++) begin
          if (query_char(i) == CH_STAR) has_star = 1'b1;
        end
        closing = has_star ? 1 : ((q_pos == qlen) ? str_score : 0);
        if (closing > rec_best) rec_best = closing;
      end
      clear_string();
    end
    if (it.r_end) begin
      closing = (qlen == 0) ? 1 : rec_best;
      want.score = closing[10:0];
      want.hit = closing != 0;
      expected_scores.push_back(want);
      rec_best = 0;
    end
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_QUERY_LENGTH) q_len = data[5:0];
    else if (addr == ADDR_HOST_ENABLE) host_on = data[0];
    else if (addr == ADDR_TAGS_ENABLE) tags_on = data[0];
    else q_word[addr[4:3]] = data;
    @(posedge clk);
  endtask

  task automatic set_query(input logic [8*QUERY_BYTES-1:0] qb, input logic [5:0] len);
    for (int i = 0; i < QWORDS; i++) begin
      write_reg(ADDR_QUERY_WORD + ADDR_W'(8 * i), qb[64 * i +: 64]);
    end
    write_reg(ADDR_QUERY_LENGTH, DATA_W'(len));
  endtask

  task automatic set_enables(input logic host, input logic tags);
    write_reg(ADDR_HOST_ENABLE, DATA_W'(host));
    write_reg(ADDR_TAGS_ENABLE, DATA_W'(tags));
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(input char_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    {string_kind, char_present, target_char, string_end, record_end} <= it;
    do @(posedge clk); while (!item_ready);
    items_sent++;
    score_item(it);
  endtask

  function automatic char_item_t make_item(input logic [1:0] kind, input logic present,
                                           input logic [7:0] ch, input logic s_end,
                                           input logic r_end);
    char_item_t it;
    it.kind = kind;
    it.present = present;
    it.ch = ch;
    it.s_end = s_end;
    it.r_end = r_end;
    return it;
  endfunction

  function automatic char_item_t random_item(input logic r_end);
    return make_item(2'($urandom_range(3)), 1'($urandom_range(1)), 8'($urandom_range(255)),
                     1'($urandom_range(1)), r_end);
  endfunction

  function automatic byte_q_t to_bytes(input string s);
    byte_q_t txt;
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    return txt;
  endfunction

  function automatic logic [8*QUERY_BYTES-1:0] pack_query(input string s);
    logic [8*QUERY_BYTES-1:0] qb;
    qb = '0;
    for (int i = 0; i < s.len(); i++) qb[8 * i +: 8] = s[i];
    return qb;
  endfunction

  // the closing item of a record may or may not also carry string_end
  task automatic send_text(input logic [1:0] kind, input byte_q_t txt, input bit closes_record);
    bit tail;
    if (txt.size() == 0) begin
      send_item(make_item(kind, 1'b0, 8'($urandom_range(255)), 1'b1, closes_record));
    end else begin
      foreach (txt[i]) begin
        tail = i == txt.size() - 1;
        send_item(make_item(kind, 1'b1, txt[i],
                            tail && (!closes_record || $urandom_range(1) == 1),
                            tail && closes_record));
      end
    end
  endtask

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        c = LOWER_A + 8'($urandom_range(3));
        if ($urandom_range(1) == 1) c = swap_case(c);
      end
      6: begin
        case ($urandom_range(2))
          0: c = CH_SPACE;
          1: c = CH_DASH;
          default: c = CH_UNDERSCORE;
        endcase
      end
      7: c = CH_DIGIT_0 + 8'($urandom_range(9));
      default: c = 8'($urandom_range(255));
    endcase
    return c;
  endfunction

  task automatic random_query(output logic [8*QUERY_BYTES-1:0] qb, output logic [5:0] len);
    int unsigned used;
    for (int i = 0; i < 8 * QUERY_BYTES; i += 32) qb[i +: 32] = $urandom();
    case ($urandom_range(19))
      0: len = 0;
      1: len = 6'($urandom_range(63, 33));
      2, 3: len = 6'($urandom_range(32, 7));
      default: len = 6'($urandom_range(6, 1));
    endcase
    used = (len > QUERY_BYTES) ? QUERY_BYTES : len;
    for (int i = 0; i < used; i++) qb[8 * i +: 8] = rand_char();
    if (used != 0 && $urandom_range(9) == 0) qb[8 * $urandom_range(used - 1) +: 8] = CH_STAR;
  endtask

  // well-formed targets carry the query in order with fillers and random case, but may lose one character
  task automatic make_target(input bit well_formed, output byte_q_t txt);
    int unsigned qlen;
    txt.delete();
    qlen = active_length();
    if (well_formed) begin
      for (int i = 0; i < qlen; i++) begin
        repeat ($urandom_range(2)) txt.push_back(rand_char());
        txt.push_back($urandom_range(1) == 1 ? swap_case(query_char(i)) : query_char(i));
      end
      if (txt.size() != 0 && $urandom_range(3) == 0) txt.delete($urandom_range(txt.size() - 1));
      repeat ($urandom_range(2)) txt.push_back(rand_char());
    end else begin
      repeat ($urandom_range(6)) txt.push_back(rand_char());
    end
  endtask

  task automatic send_record();
    logic [1:0] kinds[$];
    byte_q_t    txt;
    bit         end_apart;
    if ($urandom_range(4) != 0) kinds.push_back(KIND_NAME);
    if ($urandom_range(9) < 7) kinds.push_back(KIND_HOST);
    if ($urandom_range(9) < 7) kinds.push_back(KIND_TAGS);
    if ($urandom_range(5) == 0) kinds.insert($urandom_range(kinds.size()), KIND_SPARE);
    end_apart = kinds.size() == 0 || $urandom_range(2) == 0;
    foreach (kinds[i]) begin
      if ($urandom_range(9) == 0) send_item(random_item(1'b0));
      make_target($urandom_range(3) != 0, txt);
      send_text(kinds[i], txt, !end_apart && i == kinds.size() - 1);
    end
    if (end_apart) send_item(random_item(1'b1));
  endtask

  task automatic test_directed_cases();
    byte_q_t txt;
    send_item(make_item(KIND_NAME, 1'b0, 8'h00, 1'b0, 1'b1));
    settle();
    set_query(pack_query("ab"), 6'd2);
    send_text(KIND_NAME, to_bytes("xA-b"), 1'b1);
    send_item(make_item(KIND_SPARE, 1'b1, LOWER_A, 1'b0, 1'b0));
    send_text(KIND_NAME, to_bytes("AB"), 1'b0);
    send_text(KIND_TAGS, to_bytes("ba"), 1'b0);
    send_item(make_item(KIND_NAME, 1'b0, 8'hFF, 1'b1, 1'b1));
    settle();
    set_query(pack_query("a*"), 6'd2);
    send_item(make_item(KIND_HOST, 1'b0, 8'h00, 1'b1, 1'b0));
    send_item(make_item(KIND_SPARE, 1'b1, LOWER_Z, 1'b0, 1'b1));
    settle();
    set_enables(1'b0, 1'b0);
    send_item(make_item(KIND_HOST, 1'b1, LOWER_A, 1'b1, 1'b0));
    send_item(make_item(KIND_TAGS, 1'b1, LOWER_A, 1'b0, 1'b1));
    settle();
    set_enables(1'b1, 1'b1);
    set_query((8*QUERY_BYTES)'({8'hFF, 8'h00}), 6'd2);
    txt.push_back(8'h00);
    txt.push_back(8'hFF);
    send_text(KIND_NAME, txt, 1'b1);
    settle();
    set_query(pack_query("a"), 6'd1);
    send_text(KIND_NAME, to_bytes("aa"), 1'b1);
    settle();
  endtask

  // every matched dash starts a word, so a full match earns the word bonus on each character
  task automatic test_longest_query();
    byte_q_t txt;
    set_query({QUERY_BYTES{CH_DASH}}, 6'd63);
    repeat (QUERY_BYTES) txt.push_back(CH_DASH);
    send_text(KIND_NAME, txt, 1'b1);
    void'(txt.pop_back());
    send_text(KIND_HOST, txt, 1'b0);
    send_item(make_item(KIND_TAGS, 1'b0, 8'h00, 1'b0, 1'b1));
    settle();
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input int unsigned budget);
    logic [8*QUERY_BYTES-1:0] qb;
    logic [5:0]               len;
    int unsigned              stop;
    int unsigned              group_stop;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      random_query(qb, len);
      set_query(qb, len);
      set_enables($urandom_range(3) != 0, $urandom_range(3) != 0);
      group_stop = items_sent + 40;
      while (items_sent < group_stop && items_sent < stop) send_record();
      settle();
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_scores.size() == 0) begin
        report_error($sformatf("result with none expected: best_score %0d matched %0d",
                               best_score, matched));
      end else begin
        next_score = expected_scores.pop_front();
        if (best_score !== next_score.score)
          report_error($sformatf("best_score %0d, expected %0d", best_score, next_score.score));
        if (matched !== next_score.hit)
          report_error($sformatf("matched %0d, expected %0d", matched, next_score.hit));
      end
    end
    if ((item_valid && item_ready) || (result_valid && result_ready) || (psel && penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    result_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    do @(posedge clk); while (stall_cycles < STALL_LIMIT);
    $display("fuzzy_subsequence_scorer test failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_longest_query();
    test_random_phase(0, 0, 120);
    test_random_phase(80, 0, 120);
    test_random_phase(0, 80, 120);
    test_random_phase(30, 30, 120);
    settle();
    if (error_count == 0) begin
      $display("fuzzy_subsequence_scorer test passed");
    end else begin
      $display("fuzzy_subsequence_scorer test failed");
    end
    $finish;
  end

endmodule

// ===== fuzzy_subsequence_scorer.f =====
hdl/fss_pkg.sv
hdl/fss_regs.sv
hdl/fuzzy_subsequence_scorer.sv
test/fuzzy_subsequence_scorer_test.sv
